### hw/rtl/pttt_pkg.sv
// Shared types, step addresses and the control store for the periodic task timer table.
package pttt_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ADD  = 2'd1,
    FUNC_SET  = 2'd2,
    FUNC_GET  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_BRANCH,
    SEQ_HOLD,
    SEQ_DISPATCH
  } seq_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_TICK_SKIP,
    COND_LAST,
    COND_SLOT_BAD
  } cond_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_TICK_INIT,
    OP_TICK_EVAL,
    OP_ADD,
    OP_SET,
    OP_GET_RD,
    OP_GET_WB
  } dp_op_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_TICK  = 3'd1;
  localparam step_t STEP_LOOP  = 3'd2;
  localparam step_t STEP_ADD   = 3'd3;
  localparam step_t STEP_SET   = 3'd4;
  localparam step_t STEP_GET   = 3'd5;
  localparam step_t STEP_GETWB = 3'd6;
  localparam step_t STEP_DONE  = 3'd7;

  typedef struct packed {
    seq_e   seq;
    cond_e  cond;
    step_t  target;
    dp_op_e op;
    logic   busy;
    logic   done;
  } ctl_word_t;

  typedef struct packed {
    logic tick_skip;
    logic last;
    logic slot_bad;
  } cond_t;

  // Control store: one word per step.
  function automatic ctl_word_t ctl_rom(input step_t step);
    ctl_word_t w;
    w = '{seq: SEQ_GOTO, cond: COND_NONE, target: STEP_IDLE, op: OP_NONE,
          busy: 1'b1, done: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        w.seq  = SEQ_DISPATCH;
        w.op   = OP_LATCH;
        w.busy = 1'b0;
      end
      STEP_TICK: begin
        w.seq    = SEQ_BRANCH;
        w.cond   = COND_TICK_SKIP;
        w.target = STEP_DONE;
        w.op     = OP_TICK_INIT;
      end
      STEP_LOOP: begin
        w.seq    = SEQ_HOLD;
        w.cond   = COND_LAST;
        w.target = STEP_DONE;
        w.op     = OP_TICK_EVAL;
      end
      STEP_ADD: begin
        w.target = STEP_DONE;
        w.op     = OP_ADD;
      end
      STEP_SET: begin
        w.target = STEP_DONE;
        w.op     = OP_SET;
      end
      STEP_GET: begin
        w.seq    = SEQ_BRANCH;
        w.cond   = COND_SLOT_BAD;
        w.target = STEP_DONE;
        w.op     = OP_GET_RD;
      end
      STEP_GETWB: begin
        w.target = STEP_DONE;
        w.op     = OP_GET_WB;
      end
      STEP_DONE: begin
        w.target = STEP_IDLE;
        w.done   = 1'b1;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input func_e func);
    step_t s;
    unique case (func)
      FUNC_TICK: s = STEP_TICK;
      FUNC_ADD:  s = STEP_ADD;
      FUNC_SET:  s = STEP_SET;
      FUNC_GET:  s = STEP_GET;
      default:   s = STEP_IDLE;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/pttt_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module pttt_seq
  import pttt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  cond_t      cond_i,
  output ctl_word_t  ctl_o
);

  step_t upc_q, upc_d;
  logic  cond_sel;

  assign ctl_o = ctl_rom(upc_q);

  always_comb begin
    case (ctl_o.cond)
      COND_TICK_SKIP: cond_sel = cond_i.tick_skip;
      COND_LAST:      cond_sel = cond_i.last;
      COND_SLOT_BAD:  cond_sel = cond_i.slot_bad;
      default:        cond_sel = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl_o.seq)
      SEQ_NEXT:     upc_d = upc_q + step_t'(1);
      SEQ_GOTO:     upc_d = ctl_o.target;
      SEQ_BRANCH:   upc_d = cond_sel ? ctl_o.target : upc_q + step_t'(1);
      SEQ_HOLD:     upc_d = cond_sel ? ctl_o.target : upc_q;
      SEQ_DISPATCH: upc_d = start_i ? dispatch(func_e'(func_i)) : upc_q;
      default:      upc_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

### hw/rtl/pttt_dp.sv
// Datapath: timer tables, task count, slot walker and result registers.
module pttt_dp
  import pttt_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_word_t   ctl_i,
  input  logic        accept_i,
  input  logic        running_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  slot_i,
  input  logic [14:0] interval_ms_i,
  input  logic        enable_flag_i,
  output cond_t       cond_o,
  output logic [7:0]  fired_mask_o,
  output logic        status_o,
  output logic [2:0]  slot_out_o,
  output logic [14:0] interval_out_o
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  // Tables. Entries read as zero until their valid bit is set.
  logic [14:0]          per_mem  [MAX_TASKS];
  logic [31:0]          time_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] per_vld_q, time_vld_q, en_q;

  logic [14:0] per_rd_q;
  logic [31:0] time_rd_q;
  logic        per_rv_q, time_rv_q;

  logic [31:0] now_q;
  logic [7:0]  slot_q;
  logic [14:0] ival_q;
  logic        enf_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;

  logic [7:0]  fired_q, fired_d;
  logic        status_q, status_d;
  logic [2:0]  slot_out_q, slot_out_d;
  logic [14:0] ival_out_q, ival_out_d;

  logic          per_we, time_we, en_we;
  logic [IW-1:0] per_wa, time_wa, rd_addr;
  logic [14:0]   per_wd;

  logic [CW-1:0] idx_nxt;
  logic [14:0]   per_eff;
  logic [31:0]   time_eff, elapsed;
  logic          due, full, slot_ok;

  assign idx_nxt  = CW'(idx_q) + CW'(1);
  assign per_eff  = per_rv_q ? per_rd_q : 15'd0;
  assign time_eff = time_rv_q ? time_rd_q : 32'd0;
  assign elapsed  = now_q - time_eff;
  assign due      = elapsed > {17'd0, per_eff};
  assign full     = count_q >= CW'(MAX_TASKS);
  assign slot_ok  = slot_q < 8'(MAX_TASKS);

  assign cond_o.tick_skip = !running_i || (count_q == '0);
  assign cond_o.last      = idx_nxt == count_q;
  assign cond_o.slot_bad  = !slot_ok;

  always_comb begin
    idx_d      = idx_q;
    count_d    = count_q;
    fired_d    = fired_q;
    status_d   = status_q;
    slot_out_d = slot_out_q;
    ival_out_d = ival_out_q;
    per_we     = 1'b0;
    time_we    = 1'b0;
    en_we      = 1'b0;
    per_wa     = count_q[IW-1:0];
    time_wa    = idx_q;
    per_wd     = ival_q;
    rd_addr    = '0;
    unique case (ctl_i.op)
      OP_LATCH: begin
        if (accept_i) begin
          fired_d    = '0;
          status_d   = 1'b0;
          slot_out_d = '0;
          ival_out_d = '0;
        end
      end
      OP_TICK_INIT: begin
        idx_d = '0;
      end
      OP_TICK_EVAL: begin
        // Evaluate the entry fetched last cycle while fetching the next one.
        if (!cond_o.last) begin
          rd_addr = idx_nxt[IW-1:0];
        end
        if (due) begin
          time_we = 1'b1;
          if (en_q[idx_q]) begin
            fired_d = fired_q | (8'd1 << idx_q);
          end
        end
        idx_d = idx_nxt[IW-1:0];
      end
      OP_ADD: begin
        if (full) begin
          status_d = 1'b1;
        end else begin
          per_we     = 1'b1;
          en_we      = 1'b1;
          slot_out_d = 3'(count_q);
          count_d    = count_q + CW'(1);
        end
      end
      OP_SET: begin
        per_wa = slot_q[IW-1:0];
        if (slot_ok) begin
          per_we = 1'b1;
        end else begin
          status_d = 1'b1;
        end
      end
      OP_GET_RD: begin
        rd_addr = slot_q[IW-1:0];
        if (!slot_ok) begin
          status_d = 1'b1;
        end
      end
      OP_GET_WB: begin
        ival_out_d = per_eff;
      end
      default: begin
      end
    endcase
  end

  // Table storage with registered read data.
  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[per_wa] <= per_wd;
    end
    if (time_we) begin
      time_mem[time_wa] <= now_q;
    end
    per_rd_q  <= per_mem[rd_addr];
    time_rd_q <= time_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_vld_q  <= '0;
      time_vld_q <= '0;
      en_q       <= '0;
      per_rv_q   <= 1'b0;
      time_rv_q  <= 1'b0;
      count_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (per_we) begin
        per_vld_q[per_wa] <= 1'b1;
      end
      if (time_we) begin
        time_vld_q[time_wa] <= 1'b1;
      end
      if (en_we) begin
        en_q[per_wa] <= enf_q;
      end
      per_rv_q  <= per_vld_q[rd_addr];
      time_rv_q <= time_vld_q[rd_addr];
      count_q   <= count_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LATCH && accept_i) begin
      now_q  <= now_ms_i;
      slot_q <= slot_i;
      ival_q <= interval_ms_i;
      enf_q  <= enable_flag_i;
    end
    fired_q    <= fired_d;
    status_q   <= status_d;
    slot_out_q <= slot_out_d;
    ival_out_q <= ival_out_d;
  end

  assign fired_mask_o   = fired_q;
  assign status_o       = status_q;
  assign slot_out_o     = slot_out_q;
  assign interval_out_o = ival_out_q;

endmodule

### hw/rtl/periodic_task_timer_table.sv
// Top level of the periodic task timer table: ports, running register and block wiring.
//
// Usage. A command is transferred at a rising clock edge where start is high and
// busy is low; func_i selects tick, add task, set interval or get interval, and
// the other command fields are sampled at that edge. Each command produces exactly
// one result, shown on fired_mask_o, status_o, slot_out_o and interval_out_o for a
// single cycle while done_o is high. The receiver cannot stall: the result is
// transferred at the edge that ends the done_o cycle.
// Sequencing: add and set each run their own step and then the done step; get runs
// a read step, a write-back step (skipped for a bad slot) and the done step. A tick
// runs its init step, then, while running with slots added, the slot walker, which
// evaluates one table entry per cycle through the single table read port, then the
// done step; stopped or with no slot added it goes from init to done. The block then
// returns to its idle step, so a new command is taken only after the last one ends.
// The running register is written through its own channel (cfg_valid_i, always
// ready); write it only while no command is in flight. Reset clears the task
// count, the running register, the enable bits and all table valid bits, so
// every slot reads as interval zero and last fire time zero.
module periodic_task_timer_table
  import pttt_pkg::*;
#(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  slot_i,
  input  logic [14:0] interval_ms_i,
  input  logic        enable_flag_i,
  output logic        done_o,
  output logic [7:0]  fired_mask_o,
  output logic        status_o,
  output logic [2:0]  slot_out_o,
  output logic [14:0] interval_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  ctl_word_t ctl;
  cond_t     cond;
  logic      accept;
  logic      running_q;

  // The sequencer is in its idle step exactly when the control word drops busy.
  assign busy        = ctl.busy;
  assign done_o      = ctl.done;
  assign accept      = start && !ctl.busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
    end else if (cfg_valid_i) begin
      running_q <= cfg_data_i;
    end
  end

  pttt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .func_i (func_i),
    .cond_i (cond),
    .ctl_o  (ctl)
  );

  pttt_dp #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .accept_i      (accept),
    .running_i     (running_q),
    .now_ms_i      (now_ms_i),
    .slot_i        (slot_i),
    .interval_ms_i (interval_ms_i),
    .enable_flag_i (enable_flag_i),
    .cond_o        (cond),
    .fired_mask_o  (fired_mask_o),
    .status_o      (status_o),
    .slot_out_o    (slot_out_o),
    .interval_out_o(interval_out_o)
  );

endmodule
